// ===== design/byte_stuffed_packet_receiver_core_assert.svh =====
// ============================================================================
// Assertion macros for the byte-stuffed packet receiver
// Clocked on i_clk and held off while i_rst_n is low.
// ============================================================================
`ifndef BYTE_STUFFED_PACKET_RECEIVER_CORE_ASSERT_SVH
`define BYTE_STUFFED_PACKET_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication
`define BSPR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BSPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bspr_pkg.sv =====
// ============================================================================
// bspr_pkg
// Types, codes and helpers shared by the packet receiver modules.
// ============================================================================
`default_nettype none

package bspr_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_START   = 3'd1,
        PH_ADDRESS = 3'd2,
        PH_COUNT   = 3'd3,
        PH_DATA    = 3'd4,
        PH_CRC     = 3'd5
    } t_phase;

    // Result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Frame status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;
    localparam logic [1:0] STATUS_UNUSED  = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_END     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_FRAME_END = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_ESCAPE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_START     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH    = 3'd6;

    // Register reset values
    localparam logic [7:0] RST_FRAME_END     = 8'd192;
    localparam logic [7:0] RST_ESCAPE        = 8'd219;
    localparam logic [7:0] RST_ESC_FRAME_END = 8'd220;
    localparam logic [7:0] RST_ESC_ESCAPE    = 8'd221;
    localparam logic [7:0] RST_CRC_START     = 8'd222;
    localparam logic [7:0] RST_CRC_POLY      = 8'd140;
    localparam logic [7:0] RST_MAX_LENGTH    = 8'd64;

    // Address byte flag (top bit)
    localparam int ADDR_FLAG_BIT = 7;

    // Output stream widths
    localparam int M_TDATA_W = 48;
    localparam int M_PAD_W   = 6;

    typedef struct packed {
        logic [7:0] frame_end;
        logic [7:0] escape;
        logic [7:0] esc_frame_end;
        logic [7:0] esc_escape;
        logic [7:0] crc_start;
        logic [7:0] crc_poly;
        logic [7:0] max_length;
    } t_cfg;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] data_index;
        logic [6:0] address;
        logic       address_present;
        logic [7:0] command;
        logic [7:0] data_count;
        logic [1:0] status;
    } t_result;

    // Reflected CRC-8 over one byte, LSB first, eight unrolled steps
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc_in,
                                             input logic [7:0] data_in,
                                             input logic [7:0] poly);
        logic [7:0] crc;
        logic [7:0] d;
        crc = crc_in;
        d   = data_in;
        for (int i = 0; i < 8; i++) begin
            if (crc[0] ^ d[0]) begin
                crc = (crc >> 1) ^ poly;
            end else begin
                crc = crc >> 1;
            end
            d = d >> 1;
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ===== design/byte_stuffed_packet_receiver_core.sv =====
// ============================================================================
// byte_stuffed_packet_receiver_core
// Byte-stuffed frame receiver with address, command, length and CRC-8 check.
// ============================================================================
//
//  Channel  Dir  Content
//  -------  ---  ---------------------------------------------------------
//  s        in   raw serial byte per request
//  m        out  data byte (tuser 0) or end-of-frame status (tuser 1)
//  cfg      in   register write: index 0..6, 8-bit data, no read-back
//
//  One byte per cycle while o_s_tready is high; a byte's result is registered in the
//  output register, or in the skid entry when m stalls. The parser, CRC-8 update and
//  output register form a single pass. A two-entry output register/skid pair drops
//  o_s_tready whenever both entries are full, even in a cycle where m accepts.
//  Reset is synchronous and active low; registers return to their defaults.
//
`default_nettype none
`include "byte_stuffed_packet_receiver_core_assert.svh"

module byte_stuffed_packet_receiver_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // slave stream
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    input  wire  [7:0]                         i_s_tdata,  // [7:0] rx_byte
    // master stream
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    // [7:0] data_byte, [15:8] data_index, [22:16] address,
    // [23] address_present, [31:24] command, [39:32] data_count,
    // [41:40] status, [47:42] zero
    output logic [bspr_pkg::M_TDATA_W-1:0]     o_m_tdata,
    output logic                               o_m_tuser,  // [0] kind
    // configuration write port
    input  wire                                i_cfg_wr_en,
    input  wire  [bspr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [7:0]                         i_cfg_wdata
);

    bspr_pkg::t_cfg    r_cfg;
    bspr_pkg::t_result w_res;
    logic              w_res_valid;
    logic              w_accept;

    bspr_pkg::t_result r_out, r_skid;
    logic              r_out_valid, r_skid_valid;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_end     <= bspr_pkg::RST_FRAME_END;
            r_cfg.escape        <= bspr_pkg::RST_ESCAPE;
            r_cfg.esc_frame_end <= bspr_pkg::RST_ESC_FRAME_END;
            r_cfg.esc_escape    <= bspr_pkg::RST_ESC_ESCAPE;
            r_cfg.crc_start     <= bspr_pkg::RST_CRC_START;
            r_cfg.crc_poly      <= bspr_pkg::RST_CRC_POLY;
            r_cfg.max_length    <= bspr_pkg::RST_MAX_LENGTH;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                bspr_pkg::REG_FRAME_END:     r_cfg.frame_end     <= i_cfg_wdata;
                bspr_pkg::REG_ESCAPE:        r_cfg.escape        <= i_cfg_wdata;
                bspr_pkg::REG_ESC_FRAME_END: r_cfg.esc_frame_end <= i_cfg_wdata;
                bspr_pkg::REG_ESC_ESCAPE:    r_cfg.esc_escape    <= i_cfg_wdata;
                bspr_pkg::REG_CRC_START:     r_cfg.crc_start     <= i_cfg_wdata;
                bspr_pkg::REG_CRC_POLY:      r_cfg.crc_poly      <= i_cfg_wdata;
                bspr_pkg::REG_MAX_LENGTH:    r_cfg.max_length    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input side: blocked only while the skid entry is occupied
    assign o_s_tready = !r_skid_valid;
    assign w_accept   = i_s_tvalid && o_s_tready;

    bspr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_byte      (i_s_tdata),
        .i_cfg       (r_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_res_valid;
            end
        end else if (w_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload follows the valid flags
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_tready) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_res_valid) begin
            r_skid <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {{bspr_pkg::M_PAD_W{1'b0}}, r_out.status, r_out.data_count,
                         r_out.command, r_out.address_present, r_out.address,
                         r_out.data_index, r_out.data_byte};

    // Checks
    `BSPR_ASSERT_NOW(a_skid_needs_out, r_skid_valid, r_out_valid,
        "skid entry held while output register empty")
    `BSPR_ASSERT_NEXT(a_stall_to_skid,
        r_out_valid && !i_m_tready && w_res_valid && !r_skid_valid, r_skid_valid,
        "result under output stall not captured in skid entry")
    `BSPR_ASSERT_NOW(a_status_code, o_m_tvalid, o_m_tdata[41:40] != bspr_pkg::STATUS_UNUSED,
        "undefined status code on output")
    `BSPR_ASSERT_NOW(a_data_status_ok, o_m_tvalid && o_m_tuser == bspr_pkg::KIND_DATA,
        o_m_tdata[41:40] == bspr_pkg::STATUS_OK,
        "data result carries non-zero status")

endmodule

`default_nettype wire

// ===== design/bspr_parser.sv =====
// ============================================================================
// bspr_parser
// Destuffing, frame parsing and running CRC-8; one byte per cycle while i_valid is high.
// ============================================================================
`default_nettype none

module bspr_parser (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire  [7:0]          i_byte,
    input  bspr_pkg::t_cfg      i_cfg,
    output logic                o_res_valid,
    output bspr_pkg::t_result   o_res
);

    bspr_pkg::t_phase r_phase, n_phase;
    logic             r_esc_pend, n_esc_pend;
    logic [7:0]       r_crc, n_crc;
    logic [6:0]       r_addr, n_addr;
    logic             r_has_addr, n_has_addr;
    logic [7:0]       r_cmd, n_cmd;
    logic [7:0]       r_decl, n_decl;
    logic [7:0]       r_recv, n_recv;

    logic             w_raw_fe;
    bspr_pkg::t_phase w_phase;
    logic [7:0]       w_byte;
    logic [7:0]       w_crc_next;
    logic [7:0]       w_recv_inc;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= bspr_pkg::PH_IDLE;
            r_esc_pend <= 1'b0;
            r_crc      <= '0;
            r_addr     <= '0;
            r_has_addr <= 1'b0;
            r_cmd      <= '0;
            r_decl     <= '0;
            r_recv     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_esc_pend <= n_esc_pend;
            r_crc      <= n_crc;
            r_addr     <= n_addr;
            r_has_addr <= n_has_addr;
            r_cmd      <= n_cmd;
            r_decl     <= n_decl;
            r_recv     <= n_recv;
        end
    end

    // Raw frame end resynchronises before destuffing
    assign w_raw_fe   = (i_byte == i_cfg.frame_end);
    assign w_phase    = w_raw_fe ? bspr_pkg::PH_IDLE : r_phase;
    assign w_recv_inc = r_recv + 8'd1;

    // Destuff: map the byte after an escape
    always_comb begin
        w_byte = i_byte;
        if (r_esc_pend) begin
            if (i_byte == i_cfg.esc_frame_end) begin
                w_byte = i_cfg.frame_end;
            end else if (i_byte == i_cfg.esc_escape) begin
                w_byte = i_cfg.escape;
            end
        end
    end

    assign w_crc_next = bspr_pkg::crc8_feed(r_crc, w_byte, i_cfg.crc_poly);

    // Next state and result
    always_comb begin
        n_phase    = r_phase;
        n_esc_pend = r_esc_pend;
        n_crc      = r_crc;
        n_addr     = r_addr;
        n_has_addr = r_has_addr;
        n_cmd      = r_cmd;
        n_decl     = r_decl;
        n_recv     = r_recv;

        o_res_valid            = 1'b0;
        o_res.kind             = bspr_pkg::KIND_DATA;
        o_res.data_byte        = '0;
        o_res.data_index       = '0;
        o_res.address          = r_addr;
        o_res.address_present  = r_has_addr;
        o_res.command          = r_cmd;
        o_res.data_count       = r_decl;
        o_res.status           = bspr_pkg::STATUS_OK;

        if (i_valid) begin
            n_phase = w_phase;
            if (i_byte == i_cfg.escape && !r_esc_pend) begin
                // escape swallowed
                n_esc_pend = 1'b1;
            end else begin
                n_esc_pend = 1'b0;
                case (w_phase)
                    bspr_pkg::PH_IDLE: begin
                        if (w_byte == i_cfg.frame_end) begin
                            n_phase    = bspr_pkg::PH_START;
                            n_crc      = bspr_pkg::crc8_feed(i_cfg.crc_start,
                                                             i_cfg.frame_end,
                                                             i_cfg.crc_poly);
                            n_has_addr = 1'b0;
                            n_addr     = '0;
                        end
                    end
                    bspr_pkg::PH_START: begin
                        if (w_byte[bspr_pkg::ADDR_FLAG_BIT]) begin
                            n_addr     = w_byte[6:0];
                            n_has_addr = 1'b1;
                            n_crc      = bspr_pkg::crc8_feed(r_crc, {1'b0, w_byte[6:0]},
                                                             i_cfg.crc_poly);
                            n_phase    = bspr_pkg::PH_ADDRESS;
                        end else begin
                            n_addr  = '0;
                            n_cmd   = w_byte;
                            n_crc   = w_crc_next;
                            n_phase = bspr_pkg::PH_COUNT;
                        end
                    end
                    bspr_pkg::PH_ADDRESS: begin
                        n_cmd   = w_byte;
                        n_crc   = w_crc_next;
                        n_phase = bspr_pkg::PH_COUNT;
                    end
                    bspr_pkg::PH_COUNT: begin
                        n_decl = w_byte;
                        n_recv = '0;
                        n_crc  = w_crc_next;
                        if (w_byte > i_cfg.max_length) begin
                            // oversize: status now, back to idle
                            n_phase          = bspr_pkg::PH_IDLE;
                            o_res_valid      = 1'b1;
                            o_res.kind       = bspr_pkg::KIND_STATUS;
                            o_res.data_count = w_byte;
                            o_res.status     = bspr_pkg::STATUS_TOO_LONG;
                        end else if (w_byte != 8'd0) begin
                            n_phase = bspr_pkg::PH_DATA;
                        end else begin
                            n_phase = bspr_pkg::PH_CRC;
                        end
                    end
                    bspr_pkg::PH_DATA: begin
                        n_crc  = w_crc_next;
                        n_recv = w_recv_inc;
                        if (w_recv_inc == r_decl) begin
                            n_phase = bspr_pkg::PH_CRC;
                        end
                        o_res_valid      = 1'b1;
                        o_res.data_byte  = w_byte;
                        o_res.data_index = r_recv;
                    end
                    bspr_pkg::PH_CRC: begin
                        n_phase      = bspr_pkg::PH_IDLE;
                        o_res_valid  = 1'b1;
                        o_res.kind   = bspr_pkg::KIND_STATUS;
                        o_res.status = (w_byte == r_crc) ? bspr_pkg::STATUS_OK
                                                         : bspr_pkg::STATUS_CRC_ERR;
                    end
                    default: begin
                        n_phase = bspr_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire
